// File: src/pp6_pkg.sv
// Package for the PPM P6 stream parser: limits, character codes,
// parser state and result kind types. No dependencies.
package pp6_pkg;

  localparam int unsigned MAX_DIM    = 4096;
  localparam int unsigned MAX_DIGITS = 10;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DimW   = 13;   // width/height result fields
  localparam int unsigned TotW   = 26;   // payload count and index
  localparam int unsigned NumW   = 17;   // number value, saturating
  localparam int unsigned MulW   = NumW + 4;
  localparam int unsigned DcntW  = 4;
  localparam int unsigned FieldW = 2;

  localparam logic [NumW-1:0] NumCap    = NumW'(65536);
  localparam logic [NumW-1:0] MaxvalReq = NumW'(255);
  localparam logic [NumW-1:0] MaxDimV   = NumW'(MAX_DIM);
  localparam logic [DcntW-1:0] MaxDigV  = DcntW'(MAX_DIGITS);

  localparam logic [ByteW-1:0] ChP     = 8'h50;
  localparam logic [ByteW-1:0] Ch6     = 8'h36;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChNl    = 8'h0A;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] Ch0     = 8'h30;
  localparam logic [ByteW-1:0] Ch1     = 8'h31;
  localparam logic [ByteW-1:0] Ch9     = 8'h39;

  localparam logic [FieldW-1:0] FldWidth  = 2'd0;
  localparam logic [FieldW-1:0] FldHeight = 2'd1;
  localparam logic [FieldW-1:0] FldMaxval = 2'd2;

  typedef enum logic [2:0] {
    ST_MAGIC_P = 3'd0,
    ST_MAGIC_6 = 3'd1,
    ST_SEP     = 3'd2,
    ST_SKIP    = 3'd3,
    ST_NUM     = 3'd4,
    ST_DATA    = 3'd5
  } state_e;

  typedef enum logic [1:0] {
    KIND_HDR   = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_ERR   = 2'd2
  } kind_e;

endpackage

// File: src/ppm_p6_stream_parser.sv
// PPM P6 stream parser: header check, number parsing and pixel indexing.
// Depends on pp6_pkg.
//
//   channel  dir  handshake                fields
//   in       in   in_valid_i / in_ready_o  byte_req_i, first_i
//   out      out  out_valid_o / out_ready_i kind_o, pixel_byte_o, pixel_index_o,
//                                           width_o, height_o, image_full_o
//
// One word in, one word out; a word can be accepted every cycle while the output
// is not stalled, and its result shows in the next cycle from the result register.
// The parser state updates at the accepting edge.
// in_ready_o is high while the result register is empty or being drained,
// so a stalled output holds the input back and nothing else.
// Reset clears parser state and the result valid; no clearing pass.
module ppm_p6_stream_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [pp6_pkg::ByteW-1:0] byte_req_i,
  input  logic                      first_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output pp6_pkg::kind_e            kind_o,
  output logic [pp6_pkg::ByteW-1:0] pixel_byte_o,
  output logic [pp6_pkg::TotW-1:0]  pixel_index_o,
  output logic [pp6_pkg::DimW-1:0]  width_o,
  output logic [pp6_pkg::DimW-1:0]  height_o,
  output logic                      image_full_o
);
  import pp6_pkg::*;

  state_e             state_q, state_d, cur_state;
  logic [DcntW-1:0]   dcnt_q, dcnt_d, cur_dcnt;
  logic [NumW-1:0]    num_q, num_d, cur_num;
  logic [FieldW-1:0]  field_q, field_d, cur_field;
  logic [DimW-1:0]    width_q, width_d, cur_width;
  logic [DimW-1:0]    height_q, height_d, cur_height;
  logic [TotW-1:0]    total_q, total_d, cur_total;
  logic [TotW-1:0]    count_q, count_d, cur_count;
  logic               err_q, err_d, cur_err;

  kind_e              kind_q, kind_d;
  logic [ByteW-1:0]   pbyte_q, pbyte_d;
  logic [TotW-1:0]    pidx_q, pidx_d;
  logic               full_q, full_d;
  logic               out_valid_q;

  logic               accept;
  logic               ok;
  logic               is_blank, is_digit, is_lead;
  logic [MulW-1:0]    num_mul;
  logic [NumW-1:0]    num_add;
  logic [TotW-1:0]    total_calc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_blank = (byte_req_i == ChSpace) || (byte_req_i == ChNl) || (byte_req_i == ChTab);
  assign is_digit = (byte_req_i >= Ch0) && (byte_req_i <= Ch9);
  assign is_lead  = (byte_req_i >= Ch1) && (byte_req_i <= Ch9);

  // digit append with saturation; leading digit starts from zero
  always_comb begin
    logic [NumW-1:0] base;
    base    = (cur_state == ST_NUM) ? cur_num : '0;
    num_mul = ({4'b0, base} << 3) + ({4'b0, base} << 1) + MulW'(byte_req_i[3:0]);
    num_add = (num_mul > MulW'(NumCap)) ? NumCap : num_mul[NumW-1:0];
  end

  // 3*width*height from settled dimension registers
  always_comb begin
    logic [2*DimW-1:0] prod;
    prod       = width_q * height_q;
    total_calc = TotW'(prod) + TotW'({prod, 1'b0});
  end

  // restart on a first word, then the byte is handled as usual
  always_comb begin
    if (first_i) begin
      cur_state  = ST_MAGIC_P;
      cur_dcnt   = '0;
      cur_num    = '0;
      cur_field  = FldWidth;
      cur_width  = '0;
      cur_height = '0;
      cur_total  = '0;
      cur_count  = '0;
      cur_err    = 1'b0;
    end else begin
      cur_state  = state_q;
      cur_dcnt   = dcnt_q;
      cur_num    = num_q;
      cur_field  = field_q;
      cur_width  = width_q;
      cur_height = height_q;
      cur_total  = total_q;
      cur_count  = count_q;
      cur_err    = err_q;
    end
  end

  // next state
  always_comb begin
    state_d  = cur_state;
    dcnt_d   = cur_dcnt;
    num_d    = cur_num;
    field_d  = cur_field;
    width_d  = cur_width;
    height_d = cur_height;
    total_d  = cur_total;
    count_d  = cur_count;
    ok       = 1'b1;
    if (!cur_err) begin
      unique case (cur_state)
        ST_MAGIC_P: begin
          if (byte_req_i == ChP) state_d = ST_MAGIC_6;
          else ok = 1'b0;
        end
        ST_MAGIC_6: begin
          if (byte_req_i == Ch6) state_d = ST_SEP;
          else ok = 1'b0;
        end
        ST_SEP: begin
          if (is_blank) state_d = ST_SKIP;
          else ok = 1'b0;
        end
        ST_SKIP: begin
          if (is_blank) begin
            state_d = ST_SKIP;
          end else if (is_lead) begin
            num_d   = num_add;
            dcnt_d  = DcntW'(1);
            state_d = ST_NUM;
          end else begin
            ok = 1'b0;
          end
        end
        ST_NUM: begin
          if (is_digit) begin
            if (cur_dcnt >= MaxDigV) begin
              ok = 1'b0;
            end else begin
              num_d  = num_add;
              dcnt_d = cur_dcnt + DcntW'(1);
            end
          end else if (is_blank) begin
            num_d  = '0;
            dcnt_d = '0;
            if (cur_field == FldWidth) begin
              if (cur_num > MaxDimV) ok = 1'b0;
              else begin
                width_d = cur_num[DimW-1:0];
                field_d = FldHeight;
                state_d = ST_SKIP;
              end
            end else if (cur_field == FldHeight) begin
              if (cur_num > MaxDimV) ok = 1'b0;
              else begin
                height_d = cur_num[DimW-1:0];
                field_d  = FldMaxval;
                state_d  = ST_SKIP;
              end
            end else begin
              if (cur_num != MaxvalReq) ok = 1'b0;
              else begin
                total_d = total_calc;
                count_d = '0;
                state_d = ST_DATA;
              end
            end
          end else begin
            ok = 1'b0;
          end
        end
        ST_DATA: begin
          if (cur_count >= cur_total) ok = 1'b0;
          else count_d = cur_count + TotW'(1);
        end
        default: ok = 1'b0;
      endcase
    end
    err_d = cur_err || !ok;
  end

  // result word
  always_comb begin
    kind_d  = KIND_HDR;
    pbyte_d = '0;
    pidx_d  = '0;
    full_d  = 1'b0;
    if (err_d) begin
      kind_d = KIND_ERR;
    end else begin
      if (cur_state == ST_DATA) begin
        kind_d  = KIND_PIXEL;
        pbyte_d = byte_req_i;
        pidx_d  = cur_count;
      end
      full_d = (state_d == ST_DATA) && (count_d == total_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_MAGIC_P;
      dcnt_q      <= '0;
      num_q       <= '0;
      field_q     <= FldWidth;
      width_q     <= '0;
      height_q    <= '0;
      total_q     <= '0;
      count_q     <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q  <= state_d;
        dcnt_q   <= dcnt_d;
        num_q    <= num_d;
        field_q  <= field_d;
        width_q  <= width_d;
        height_q <= height_d;
        total_q  <= total_d;
        count_q  <= count_d;
        err_q    <= err_d;
      end
      if (accept) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_d;
      pbyte_q <= pbyte_d;
      pidx_q  <= pidx_d;
      full_q  <= full_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign pixel_byte_o  = pbyte_q;
  assign pixel_index_o = pidx_q;
  // dimension registers change only on accept, together with the result word
  assign width_o       = width_q;
  assign height_o      = height_q;
  assign image_full_o  = full_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= total_q)
    else $error("payload count passed the payload total");

  a_pixel_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_PIXEL) |-> (pixel_index_o < total_q))
    else $error("pixel index outside payload");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q && accept && !first_i) |=> (err_q && out_valid_o && kind_o == KIND_ERR))
    else $error("error flag dropped without restart");
`endif

endmodule
